// ----- rtl/mcr_pkg.sv -----
// Package for the midpoint circle rasterizer: default sizes, register
// indexes and the constants of the midpoint decision rule. No dependencies.
package mcr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int PIXEL_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_RADIUS        = 3'd2,
    CFG_BITMAP_WIDTH  = 3'd3,
    CFG_BITMAP_HEIGHT = 3'd4,
    CFG_PIXEL_COLOR   = 3'd5
  } cfg_index_t;

  localparam int RESET_BITMAP_WIDTH  = 640;
  localparam int RESET_BITMAP_HEIGHT = 480;

  // d starts at DEC_INIT - 2r; a diagonal move adds 4(x-y)+DEC_DIAG,
  // a straight move adds 4x+DEC_AXIS.
  localparam int DEC_INIT = 3;
  localparam int DEC_DIAG = 10;
  localparam int DEC_AXIS = 6;

  localparam int POINTS_PER_STEP = 8;
  localparam int POINT_SEL_BITS  = 3;

endpackage

// ----- rtl/mcr_req_if.sv -----
// Request channel of the midpoint circle rasterizer: one restart/advance item.
// No dependencies.
interface mcr_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ----- rtl/mcr_pix_if.sv -----
// Point channel of the midpoint circle rasterizer: one emitted point per item.
// Widths follow the coordinate and pixel sizes of the rasterizer.
interface mcr_pix_if #(
  parameter int COORD_BITS = 12,
  parameter int PIXEL_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS:0]   point_x;
  logic signed [COORD_BITS:0]   point_y;
  logic [PIXEL_BITS-1:0]        color_out;
  logic                         in_bounds;
  logic                         last_of_step;
  logic                         circle_done;

  modport source (output valid, output point_x, output point_y, output color_out,
                  output in_bounds, output last_of_step, output circle_done,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input color_out,
                  input in_bounds, input last_of_step, input circle_done,
                  output ready);
endinterface

// ----- rtl/mcr_front.sv -----
// Step engine of the midpoint circle rasterizer: takes restart/advance items,
// walks the decision rule and pushes one step record per restart or per advance while a circle runs. Uses mcr_pkg.
module mcr_front
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_restart,
  output logic                         item_ready,
  input  logic [COORD_BITS-2:0]        radius,
  input  logic                         queue_full,
  output logic                         push,
  output logic signed [COORD_BITS-1:0] push_x,
  output logic signed [COORD_BITS-1:0] push_y,
  output logic                         push_done
);

  localparam int DEC_BITS = COORD_BITS + 4;

  logic signed [COORD_BITS-1:0] step_x, step_x_next;
  logic signed [COORD_BITS-1:0] step_y, step_y_next;
  logic signed [DEC_BITS-1:0]   decision, decision_next;
  logic                         running, running_next;
  logic                         done_next;
  logic signed [DEC_BITS-1:0]   dx_ext, dy_ext, delta;
  logic                         accept;

  assign item_ready = !queue_full;
  assign accept     = item_valid && item_ready;

  always_comb begin
    step_x_next   = step_x + COORD_BITS'(1);
    step_y_next   = step_y;
    dx_ext        = DEC_BITS'(step_x_next);
    dy_ext        = DEC_BITS'(step_y);
    delta         = (dx_ext <<< 2) + DEC_BITS'(DEC_AXIS);
    if (decision > 0) begin
      step_y_next = step_y - COORD_BITS'(1);
      dy_ext      = DEC_BITS'(step_y_next);
      delta       = ((dx_ext - dy_ext) <<< 2) + DEC_BITS'(DEC_DIAG);
    end
    decision_next = decision + delta;
    done_next     = step_y_next < step_x_next;
    running_next  = running && !done_next;
    if (item_restart) begin
      step_x_next   = '0;
      step_y_next   = $signed(COORD_BITS'(radius));
      decision_next = DEC_BITS'(DEC_INIT) - (DEC_BITS'(radius) << 1);
      done_next     = 1'b0;
      running_next  = 1'b1;
    end
  end

  assign push      = accept && (item_restart || running);
  assign push_x    = step_x_next;
  assign push_y    = step_y_next;
  assign push_done = done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x   <= '0;
      step_y   <= '0;
      decision <= '0;
      running  <= 1'b0;
    end else if (push) begin
      step_x   <= step_x_next;
      step_y   <= step_y_next;
      decision <= decision_next;
      running  <= running_next;
    end
  end

endmodule

// ----- rtl/mcr_queue.sv -----
// Short FIFO of step records between the step engine and the point
// generator of the midpoint circle rasterizer. Uses mcr_pkg for its depth.
module mcr_queue
  import mcr_pkg::*;
#(
  parameter int WIDTH = 2 * COORD_BITS_DEF + 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_pop;

  assign full   = count == CNT_BITS'(DEPTH);
  assign empty  = count == '0;
  assign head   = mem[rd_ptr];
  assign do_pop = pop && !empty;

  function automatic logic [PTR_BITS-1:0] wrap_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      count <= count + CNT_BITS'(push && !full) - CNT_BITS'(do_pop);
    end
  end

endmodule

// ----- rtl/mcr_back.sv -----
// Point generator of the midpoint circle rasterizer: expands each step record
// into its eight reflections, one per cycle while the output is not stalled,
// into an output register. Uses mcr_pkg.
module mcr_back
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         queue_empty,
  input  logic signed [COORD_BITS-1:0] head_x,
  input  logic signed [COORD_BITS-1:0] head_y,
  input  logic                         head_done,
  output logic                         pop,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-1:0]        bitmap_width,
  input  logic [COORD_BITS-1:0]        bitmap_height,
  input  logic [PIXEL_BITS-1:0]        pixel_color,
  mcr_pix_if.source                    pix
);

  localparam int PT_BITS = COORD_BITS + 1;

  logic [POINT_SEL_BITS-1:0] sel;
  logic                      load;
  logic signed [PT_BITS-1:0] off_a, off_b, px, py;
  logic                      inb;

  assign load = !queue_empty && (!pix.valid || pix.ready);
  assign pop  = load && (sel == POINT_SEL_BITS'(POINTS_PER_STEP - 1));

  // First four points offset by (x,y), last four by (y,x); bit 0 mirrors the
  // column, bit 1 the row.
  always_comb begin
    off_a = sel[2] ? PT_BITS'(head_y) : PT_BITS'(head_x);
    off_b = sel[2] ? PT_BITS'(head_x) : PT_BITS'(head_y);
    px    = sel[0] ? PT_BITS'(center_x) - off_a : PT_BITS'(center_x) + off_a;
    py    = sel[1] ? PT_BITS'(center_y) - off_b : PT_BITS'(center_y) + off_b;
    inb   = !px[PT_BITS-1] && !py[PT_BITS-1] &&
            (px[COORD_BITS-1:0] < bitmap_width) &&
            (py[COORD_BITS-1:0] < bitmap_height);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix.point_x      <= px;
      pix.point_y      <= py;
      pix.color_out    <= pixel_color;
      pix.in_bounds    <= inb;
      pix.last_of_step <= sel == POINT_SEL_BITS'(POINTS_PER_STEP - 1);
      pix.circle_done  <= head_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      sel       <= '0;
    end else begin
      if (load) begin
        pix.valid <= 1'b1;
        sel       <= sel + POINT_SEL_BITS'(1);
      end else if (pix.ready) begin
        pix.valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/midpoint_circle_rasterizer.sv -----
// Midpoint circle rasterizer: top level with the register file, the step
// engine, the step queue and the point generator. Uses mcr_pkg and the
// mcr_req_if / mcr_pix_if interfaces.
//
// Each request item either restarts the circle at (0, radius) or advances the
// midpoint walk by one step; every step yields eight points, the octant
// reflections about the centre, each flagged in or out of the bitmap, with
// the eighth marked last_of_step and all eight of the closing step marked
// circle_done. An advance while no circle is running yields nothing. The step
// engine takes one request per cycle while the two-entry step queue has room;
// the point generator then expands each step into its eight points, one point
// per cycle into the output register while the receiver is not stalling, so
// the single point output port sets the sustained throughput. With the point
// generator idle, the first point of a step passes through the step queue and
// then the output register. Radius is sampled at restart; centre, colour and
// bitmap size are sampled as points are formed, so write registers only while
// the block is idle.
module midpoint_circle_rasterizer
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int CFG_DATA_BITS = (PIXEL_BITS > COORD_BITS) ? PIXEL_BITS : COORD_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  mcr_req_if.sink                   req,
  mcr_pix_if.source                 pix,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int ENTRY_BITS = 2 * COORD_BITS + 1;

  // Configuration registers
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-2:0]        radius;
  logic [COORD_BITS-1:0]        bitmap_width;
  logic [COORD_BITS-1:0]        bitmap_height;
  logic [PIXEL_BITS-1:0]        pixel_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      radius        <= '0;
      bitmap_width  <= COORD_BITS'(RESET_BITMAP_WIDTH);
      bitmap_height <= COORD_BITS'(RESET_BITMAP_HEIGHT);
      pixel_color   <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_CENTER_X:      center_x      <= cfg_data[COORD_BITS-1:0];
        CFG_CENTER_Y:      center_y      <= cfg_data[COORD_BITS-1:0];
        CFG_RADIUS:        radius        <= cfg_data[COORD_BITS-2:0];
        CFG_BITMAP_WIDTH:  bitmap_width  <= cfg_data[COORD_BITS-1:0];
        CFG_BITMAP_HEIGHT: bitmap_height <= cfg_data[COORD_BITS-1:0];
        CFG_PIXEL_COLOR:   pixel_color   <= cfg_data[PIXEL_BITS-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Step engine -> queue
  logic                         push;
  logic signed [COORD_BITS-1:0] push_x, push_y;
  logic                         push_done;
  logic                         queue_full, queue_empty, pop;
  logic [ENTRY_BITS-1:0]        head;

  mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (req.valid),
    .item_restart (req.restart),
    .item_ready   (req.ready),
    .radius       (radius),
    .queue_full   (queue_full),
    .push         (push),
    .push_x       (push_x),
    .push_y       (push_y),
    .push_done    (push_done)
  );

  mcr_queue #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_done, push_y, push_x}),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // Queue -> point generator
  mcr_back #(.COORD_BITS(COORD_BITS), .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .head_x        (head[COORD_BITS-1:0]),
    .head_y        (head[2*COORD_BITS-1:COORD_BITS]),
    .head_done     (head[ENTRY_BITS-1]),
    .pop           (pop),
    .center_x      (center_x),
    .center_y      (center_y),
    .bitmap_width  (bitmap_width),
    .bitmap_height (bitmap_height),
    .pixel_color   (pixel_color),
    .pix           (pix)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for midpoint_circle_rasterizer: drives restart/advance
// items and register writes, predicts every emitted point and checks them.
// Depends on mcr_pkg, mcr_req_if and mcr_pix_if from the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcr_pkg::*;

  localparam int CB          = 12;
  localparam int PB          = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 370;
  // Cycles to let pass once nothing is expected; covers an advance that
  // yields no points but is still in the pipe.
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [CB:0] x;
    logic signed [CB:0] y;
    logic [PB-1:0]      color;
    logic               inb;
    logic               last;
    logic               done;
  } pixel_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [PB-1:0]             cfg_data;

  mcr_req_if                                   req_ch ();
  mcr_pix_if #(.COORD_BITS(CB), .PIXEL_BITS(PB)) pix_ch ();

  midpoint_circle_rasterizer #(.COORD_BITS(CB), .PIXEL_BITS(PB)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .pix       (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Items still to offer (restart bit) and points still owed by the block.
  bit     pending_requests[$];
  pixel_t expected_pixels[$];

  // Register shadow, reset values as the block's.
  logic signed [CB-1:0] shadow_cx;
  logic signed [CB-1:0] shadow_cy;
  logic [CB-2:0]        shadow_radius;
  logic [CB-1:0]        shadow_width;
  logic [CB-1:0]        shadow_height;
  logic [PB-1:0]        shadow_color;

  // Walk state of the predicted circle.
  int walk_x;
  int walk_y;
  int walk_d;
  bit walk_on;

  int err_count;
  int cycle_count;
  int items_queued;
  int items_taken;
  int points_seen;
  int circles_closed;
  int phases_run;

  // Sender and receiver shaping, set per phase.
  int stall_pct;
  bit sender_eager;
  bit hold_arm;
  int hold_left;
  int burst_left;
  int gap_left;
  bit req_taken;

  // Clock, and every input at a known value from time zero.
  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_CENTER_X;
    cfg_data     = '0;
    req_ch.valid   = 1'b0;
    req_ch.restart = 1'b0;
    pix_ch.ready   = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    err_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Form one point and its in-bitmap flag against the current shadow.
  task automatic push_pixel(int px, int py, bit last, bit done);
    pixel_t p;
    p.x     = px[CB:0];
    p.y     = py[CB:0];
    p.color = shadow_color;
    p.inb   = (px >= 0) && (py >= 0) &&
              (px < int'(shadow_width)) && (py < int'(shadow_height));
    p.last  = last;
    p.done  = done;
    expected_pixels.push_back(p);
  endtask

  // Eight reflections in the block's output order; the eighth is last.
  task automatic emit_octants(int x, int y, bit done);
    int cx;
    int cy;
    cx = int'(shadow_cx);
    cy = int'(shadow_cy);
    push_pixel(cx + x, cy + y, 1'b0, done);
    push_pixel(cx - x, cy + y, 1'b0, done);
    push_pixel(cx + x, cy - y, 1'b0, done);
    push_pixel(cx - x, cy - y, 1'b0, done);
    push_pixel(cx + y, cy + x, 1'b0, done);
    push_pixel(cx - y, cy + x, 1'b0, done);
    push_pixel(cx + y, cy - x, 1'b0, done);
    push_pixel(cx - y, cy - x, 1'b1, done);
  endtask

  // One item of the midpoint walk: restart at the top point, or advance.
  task automatic predict_request(bit restart);
    bit done;
    if (restart) begin
      // Radius is latched here; a running circle is simply dropped.
      walk_x  = 0;
      walk_y  = int'(shadow_radius);
      walk_d  = DEC_INIT - 2 * walk_y;
      walk_on = 1'b1;
      emit_octants(walk_x, walk_y, 1'b0);
    end else if (walk_on) begin
      walk_x++;
      if (walk_d > 0) begin
        walk_y--;
        walk_d += 4 * (walk_x - walk_y) + DEC_DIAG;
      end else begin
        walk_d += 4 * walk_x + DEC_AXIS;
      end
      done = walk_y < walk_x;
      if (done) begin
        walk_on = 1'b0;
        circles_closed++;
      end
      emit_octants(walk_x, walk_y, done);
    end
    // An advance with no circle running yields nothing.
  endtask

  // Input side at the rising edge: track register writes, predict every
  // accepted item and drop it from the pending list.
  always @(posedge clk) begin
    if (rst) begin
      shadow_cx     = '0;
      shadow_cy     = '0;
      shadow_radius = '0;
      shadow_width  = CB'(RESET_BITMAP_WIDTH);
      shadow_height = CB'(RESET_BITMAP_HEIGHT);
      shadow_color  = '0;
      walk_x  = 0;
      walk_y  = 0;
      walk_d  = 0;
      walk_on = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X:      shadow_cx     = cfg_data[CB-1:0];
          CFG_CENTER_Y:      shadow_cy     = cfg_data[CB-1:0];
          CFG_RADIUS:        shadow_radius = cfg_data[CB-2:0];
          CFG_BITMAP_WIDTH:  shadow_width  = cfg_data[CB-1:0];
          CFG_BITMAP_HEIGHT: shadow_height = cfg_data[CB-1:0];
          CFG_PIXEL_COLOR:   shadow_color  = cfg_data;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        predict_request(req_ch.restart);
        void'(pending_requests.pop_front());
        items_taken++;
        req_taken = 1'b1;
      end
    end
  end

  // Sender: offer the head of the pending list in bursts with gaps between.
  // Hold an offer until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_taken) begin
      // hold the current item
    end else begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        req_ch.valid   <= 1'b1;
        req_ch.restart <= pending_requests[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          if (sender_eager || $urandom_range(0, 2) == 0) gap_left = 0;
          else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(10, 30);
          else gap_left = $urandom_range(1, 5);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls at the phase's rate, plus one long hold-off
  // when armed, so the step queue fills and the input backs up.
  always @(negedge clk) begin
    if (hold_arm) begin
      hold_left = HOLD_CYCLES;
      hold_arm  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pix_ch.ready <= 1'b0;
    end else begin
      pix_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Output side: check each accepted point against the oldest expectation.
  always @(posedge clk) begin
    pixel_t exp_p;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      points_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("point (%0d,%0d) with nothing expected",
                                  pix_ch.point_x, pix_ch.point_y));
      end else begin
        exp_p = expected_pixels.pop_front();
        if (pix_ch.point_x !== exp_p.x)
          report_mismatch($sformatf("point_x got %0d want %0d", pix_ch.point_x, exp_p.x));
        if (pix_ch.point_y !== exp_p.y)
          report_mismatch($sformatf("point_y got %0d want %0d", pix_ch.point_y, exp_p.y));
        if (pix_ch.color_out !== exp_p.color)
          report_mismatch($sformatf("color_out got %h want %h", pix_ch.color_out, exp_p.color));
        if (pix_ch.in_bounds !== exp_p.inb)
          report_mismatch($sformatf("in_bounds got %b want %b at (%0d,%0d)",
                                    pix_ch.in_bounds, exp_p.inb, exp_p.x, exp_p.y));
        if (pix_ch.last_of_step !== exp_p.last)
          report_mismatch($sformatf("last_of_step got %b want %b",
                                    pix_ch.last_of_step, exp_p.last));
        if (pix_ch.circle_done !== exp_p.done)
          report_mismatch($sformatf("circle_done got %b want %b",
                                    pix_ch.circle_done, exp_p.done));
      end
    end
  end

  task automatic queue_item(bit restart);
    pending_requests.push_back(restart);
    items_queued++;
  endtask

  task automatic write_register(cfg_index_t idx, logic [PB-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  // Write all six registers, then drop the write enable.
  task automatic write_config(logic [PB-1:0] cx, logic [PB-1:0] cy, logic [PB-1:0] r,
                              logic [PB-1:0] w, logic [PB-1:0] h, logic [PB-1:0] col);
    write_register(CFG_CENTER_X, cx);
    write_register(CFG_CENTER_Y, cy);
    write_register(CFG_RADIUS, r);
    write_register(CFG_BITMAP_WIDTH, w);
    write_register(CFG_BITMAP_HEIGHT, h);
    write_register(CFG_PIXEL_COLOR, col);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item is taken and every point has come, then settle.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_pixels.size() != 0 || req_ch.valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    phases_run++;
  endtask

  // Random centre: mostly near the bitmap, sometimes anywhere or at the ends.
  function automatic logic [PB-1:0] pick_centre();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'h0000_07FF;
      2:       return 32'h0000_0800;
      default: return $urandom_range(0, 700);
    endcase
  endfunction

  function automatic logic [PB-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return 2048;
      2:       return $urandom_range(1, 8);
      default: return $urandom_range(1, 700);
    endcase
  endfunction

  initial begin
    int phase_r;
    int adv;
    int n;
    logic [PB-1:0] r_word;

    stall_pct    = 0;
    sender_eager = 1'b0;
    hold_arm     = 1'b0;
    hold_left    = 0;
    burst_left   = 0;
    gap_left     = 0;
    req_taken    = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset registers; idle advances, then a zero-radius circle
    // which closes on its first advance, then an idle advance again.
    queue_item(1'b0);
    queue_item(1'b0);
    queue_item(1'b1);
    queue_item(1'b0);
    queue_item(1'b0);
    wait_drained();

    // Directed: largest radius at the top corner, bitmap size written as 4096
    // so it wraps to zero and nothing is in bounds; restart mid-circle.
    stall_pct = 30;
    write_config(32'h0000_07FF, 32'hFFFF_F800, 32'h0000_07FF, 32'h0000_1000, 32'h0000_1000,
                 32'hFFFF_FFFF);
    queue_item(1'b1);
    queue_item(1'b0);
    queue_item(1'b0);
    queue_item(1'b0);
    queue_item(1'b1);
    queue_item(1'b0);
    wait_drained();

    // Directed: opposite corner, widest bitmap, one row high.
    stall_pct = 0;
    write_config(32'h0000_0800, 32'h0000_07FF, 32'h0000_07FF, 32'h0000_0FFF, 1, 0);
    queue_item(1'b1);
    queue_item(1'b0);
    queue_item(1'b0);
    wait_drained();

    // Directed: small circle walked to its end, touching the x=y diagonal,
    // with two spare advances after it has closed.
    stall_pct = 50;
    write_config(10, 10, 5, 20, 20, 32'hA5A5_5A5A);
    queue_item(1'b1);
    for (int i = 0; i < 6; i++) queue_item(1'b0);
    wait_drained();

    // Random phases until the item budget is spent.
    while (items_queued < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) phase_r = $urandom_range(0, 2047);
      else phase_r = $urandom_range(0, 24);
      // Random upper bits: the register keeps only its own width.
      r_word = {21'($urandom_range(0, 2097151)), 11'(phase_r)};
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 80;
      endcase
      sender_eager = ($urandom_range(0, 3) == 0);
      if (phases_run == 5) begin
        // Long hold-off phase: eager sender, no random stalls.
        stall_pct    = 0;
        sender_eager = 1'b1;
        phase_r      = 16;
        r_word       = 16;
      end
      write_config(pick_centre(), pick_centre(), r_word, pick_size(), pick_size(), $urandom);

      n = 0;
      while (n < 36) begin
        if ($urandom_range(0, 4) != 0) begin
          // Well-formed circle: restart, then enough advances to close it
          // most of the time, now and then a few idle ones beyond.
          queue_item(1'b1);
          n++;
          if (phase_r <= 24) adv = $urandom_range(phase_r * 3 / 4, phase_r + 3);
          else adv = $urandom_range(1, 30);
          for (int i = 0; i < adv; i++) begin
            queue_item(1'b0);
            n++;
          end
        end else begin
          // Noise: a short random run of restarts and advances.
          adv = $urandom_range(1, 6);
          for (int i = 0; i < adv; i++) begin
            queue_item(1'($urandom_range(0, 1)));
            n++;
          end
        end
      end
      if (phases_run == 5) hold_arm = 1'b1;
      wait_drained();
    end

    $display("run: %0d items taken over %0d phases, %0d points checked, %0d circles closed",
             items_taken, phases_run, points_seen, circles_closed);
    $display("      %0d mismatches", err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
